### src/lse_pkg.sv
package lse_pkg;

	localparam int HEADER_BITS   = 32;
	localparam int HEADER_PIXELS = (HEADER_BITS + 2) / 3;

	localparam int MSG_BYTES_W = 20;
	localparam int BITS_W      = 23;
	localparam int HDR_CNT_W   = 5;
	localparam int QUEUE_W     = 16;
	localparam int QCNT_W      = 5;
	localparam int PIX_W       = 8;
	localparam int BYTE_BITS   = 8;
	localparam int LEN_IDX_W   = 6;

	localparam logic [PIX_W-1:0] LSB_CLEAR = 8'hFE;

	typedef enum logic {
		CMD_BYTE  = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_PASS    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DROP     = 2'd1,
		ST_UNDERRUN = 2'd2
	} status_t;

	typedef struct packed {
		logic [HDR_CNT_W-1:0] hdr_cnt;
		logic [BITS_W-1:0]    bits_written;
		logic [QUEUE_W-1:0]   queue;
		logic [QCNT_W-1:0]    q_count;
	} emb_state_t;

endpackage

### src/lsb_stego_embedder.sv
// LSB embedder for an RGB pixel stream. Push message bytes (cmd 0) and pixels (cmd 1)
// through one valid/ready channel; every word yields exactly one result word. The
// first header pixels carry the message length in bits, then pixels carry the queued
// message bits MSB first, then pixels pass unchanged. One word is taken per clock
// while the result word is not stalled; a word passes the input register, then the step
// logic that updates the embed state and fills the result register in the same cycle.
// Write msg_bytes only while the block is idle.
module lsb_stego_embedder import lse_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic [7:0]              msg_byte,
	input  logic [PIX_W-1:0]        red_in,
	input  logic [PIX_W-1:0]        green_in,
	input  logic [PIX_W-1:0]        blue_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PIX_W-1:0]        red_out,
	output logic [PIX_W-1:0]        green_out,
	output logic [PIX_W-1:0]        blue_out,
	output logic [1:0]              phase,
	output logic [1:0]              status,
	input  logic                    cfg_we,
	input  logic [MSG_BYTES_W-1:0] cfg_wdata
);

	logic [MSG_BYTES_W-1:0] msg_bytes_q;
	emb_state_t             st_q;
	emb_state_t             st_nxt;

	logic                   valid_s1;
	logic                   cmd_s1;
	logic [7:0]             byte_s1;
	logic [PIX_W-1:0]       red_s1;
	logic [PIX_W-1:0]       green_s1;
	logic [PIX_W-1:0]       blue_s1;

	logic                   valid_s2;
	logic [PIX_W-1:0]       red_s2;
	logic [PIX_W-1:0]       green_s2;
	logic [PIX_W-1:0]       blue_s2;
	phase_t                 phase_s2;
	status_t                status_s2;

	logic [PIX_W-1:0]       red_res;
	logic [PIX_W-1:0]       green_res;
	logic [PIX_W-1:0]       blue_res;
	phase_t                 phase_res;
	status_t                status_res;

	logic                   ready_s2;
	logic                   adv_s1;

	assign ready_s2 = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && ready_s2;
	assign in_ready = !valid_s1 || ready_s2;

	lse_step u_step (
		.st         (st_q),
		.msg_bytes  (msg_bytes_q),
		.cmd        (cmd_s1),
		.msg_byte   (byte_s1),
		.red_in     (red_s1),
		.green_in   (green_s1),
		.blue_in    (blue_s1),
		.st_nxt     (st_nxt),
		.red_res    (red_res),
		.green_res  (green_res),
		.blue_res   (blue_res),
		.phase_res  (phase_res),
		.status_res (status_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_bytes_q <= '0;
			st_q        <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (cfg_we) begin
				msg_bytes_q <= cfg_wdata;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			// advance the embed state once per word leaving the input register
			if (adv_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= cmd;
			byte_s1  <= msg_byte;
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
		end
		if (adv_s1) begin
			red_s2    <= red_res;
			green_s2  <= green_res;
			blue_s2   <= blue_res;
			phase_s2  <= phase_res;
			status_s2 <= status_res;
		end
	end

	assign out_valid = valid_s2;
	assign red_out   = red_s2;
	assign green_out = green_s2;
	assign blue_out  = blue_s2;
	assign phase     = phase_s2;
	assign status    = status_s2;

endmodule

### src/lse_step.sv
module lse_step import lse_pkg::*; (
	input  emb_state_t              st,
	input  logic [MSG_BYTES_W-1:0] msg_bytes,
	input  logic                    cmd,
	input  logic [7:0]              msg_byte,
	input  logic [PIX_W-1:0]        red_in,
	input  logic [PIX_W-1:0]        green_in,
	input  logic [PIX_W-1:0]        blue_in,
	output emb_state_t              st_nxt,
	output logic [PIX_W-1:0]        red_res,
	output logic [PIX_W-1:0]        green_res,
	output logic [PIX_W-1:0]        blue_res,
	output phase_t                  phase_res,
	output status_t                 status_res
);

	logic [BITS_W-1:0]            total;
	logic [2**LEN_IDX_W-1:0]      len_ext;
	phase_t                       ph;

	assign total   = {msg_bytes, 3'b000};
	assign len_ext = (2**LEN_IDX_W)'(total);

	always_comb begin
		if (st.hdr_cnt < HDR_CNT_W'(HEADER_PIXELS)) begin
			ph = PH_HEADER;
		end else if (st.bits_written < total) begin
			ph = PH_PAYLOAD;
		end else begin
			ph = PH_PASS;
		end
	end

	always_comb begin
		logic [2:0][PIX_W-1:0] ch;
		logic [BITS_W-1:0]     wr;
		logic [QCNT_W-1:0]     qc;
		logic [QCNT_W-1:0]     qm1;
		logic [6:0]            idx;
		status_t               stt;

		st_nxt = st;
		ch     = {blue_in, green_in, red_in};
		wr     = st.bits_written;
		qc     = st.q_count;
		qm1    = '0;
		idx    = '0;
		stt    = ST_OK;

		if (cmd == CMD_BYTE) begin
			ch = '0;
			// drop the word when fewer than eight bits are free
			if (qc > QCNT_W'(QUEUE_W - BYTE_BITS)) begin
				stt = ST_DROP;
			end else begin
				st_nxt.queue   = {st.queue[QUEUE_W-BYTE_BITS-1:0], msg_byte};
				st_nxt.q_count = qc + QCNT_W'(BYTE_BITS);
			end
		end else begin
			unique case (ph)
				PH_HEADER: begin
					for (int c = 0; c < 3; c++) begin
						idx   = 7'(st.hdr_cnt) * 7'd3 + 7'(c);
						ch[c] = (ch[c] & LSB_CLEAR) | PIX_W'(len_ext[idx[LEN_IDX_W-1:0]]);
					end
					st_nxt.hdr_cnt = st.hdr_cnt + 1'b1;
				end
				PH_PAYLOAD: begin
					// oldest queued bit sits at q_count - 1
					for (int c = 0; c < 3; c++) begin
						if (wr < total) begin
							if (qc == '0) begin
								stt = ST_UNDERRUN;
							end else begin
								qm1   = qc - 1'b1;
								ch[c] = (ch[c] & LSB_CLEAR) | PIX_W'(st.queue[qm1[3:0]]);
								qc    = qm1;
								wr    = wr + 1'b1;
							end
						end
					end
					st_nxt.q_count      = qc;
					st_nxt.bits_written = wr;
				end
				default: begin
				end
			endcase
		end

		red_res    = ch[0];
		green_res  = ch[1];
		blue_res   = ch[2];
		status_res = stt;
	end

	assign phase_res = ph;

endmodule

### src/lse_checker.sv
module lse_checker import lse_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [PIX_W-1:0]        red_out,
	input logic [PIX_W-1:0]        green_out,
	input logic [PIX_W-1:0]        blue_out,
	input logic [1:0]              phase,
	input logic [1:0]              status
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(phase) && $stable(status))
		else $error("result word changed while stalled");

	// a dropped byte is a byte push, so its channels are zero
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DROP |-> red_out == '0 && green_out == '0
			&& blue_out == '0)
		else $error("dropped byte result carries pixel data");

	// underrun happens only on payload pixels
	a_underrun_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNDERRUN |-> phase == PH_PAYLOAD)
		else $error("underrun outside payload phase");

	// an accepted word, taken while no result is waiting, passes the input and result registers to show up as a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid)
		else $error("accepted word produced no result");

endmodule

bind lsb_stego_embedder lse_checker u_lse_checker (.*);

### bench/lsb_stego_embedder_test.sv
`timescale 1ns / 100ps

module lsb_stego_embedder_test;
	import lse_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		phase_t           ph;
		status_t          st;
	} pixel_word_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   cmd;
	logic [7:0]             msg_byte;
	logic [PIX_W-1:0]       red_in;
	logic [PIX_W-1:0]       green_in;
	logic [PIX_W-1:0]       blue_in;
	logic                   out_valid;
	logic                   out_ready;
	logic [PIX_W-1:0]       red_out;
	logic [PIX_W-1:0]       green_out;
	logic [PIX_W-1:0]       blue_out;
	logic [1:0]             phase;
	logic [1:0]             status;
	logic                   cfg_we;
	logic [MSG_BYTES_W-1:0] cfg_wdata;

	// embedder state as the testbench tracks it
	logic [MSG_BYTES_W-1:0] len_bytes;
	logic [HDR_CNT_W-1:0]   hdr_seen;
	logic [BITS_W-1:0]      bits_done;
	logic [QUEUE_W-1:0]     q_bits;
	logic [QCNT_W-1:0]      q_count;

	pixel_word_t embedded_due[$];
	int          fail_count;
	int          cycle_count;
	int          src_idle_pct;
	int          sink_stall_pct;

	lsb_stego_embedder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.msg_byte  (msg_byte),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.phase     (phase),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [BITS_W-1:0] total_bits();
		return {len_bytes, 3'b000};
	endfunction

	function automatic phase_t phase_now();
		if (hdr_seen < HEADER_PIXELS)
			return PH_HEADER;
		if (bits_done < total_bits())
			return PH_PAYLOAD;
		return PH_PASS;
	endfunction

	// Advance the tracked state by one accepted word and return the word it yields.
	function automatic pixel_word_t embed_step(cmd_t c, logic [7:0] b,
			logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] bl);
		pixel_word_t      res;
		logic [PIX_W-1:0] ch [3];
		logic [63:0]      len_bits;
		logic [5:0]       idx;
		int               k;
		res = '0;
		res.st = ST_OK;
		if (c == CMD_BYTE) begin
			if (q_count + BYTE_BITS > QUEUE_W) begin
				res.st = ST_DROP;
			end else begin
				q_bits = {q_bits[7:0], b};
				q_count = QCNT_W'(q_count + BYTE_BITS);
			end
			res.ph = phase_now();
			return res;
		end
		ch[0] = r;
		ch[1] = g;
		ch[2] = bl;
		res.ph = phase_now();
		if (res.ph == PH_HEADER) begin
			// length goes out LSB first, three bits per header pixel
			len_bits = 64'(total_bits());
			for (k = 0; k < 3; k++) begin
				idx = 6'(int'(hdr_seen) * 3 + k);
				ch[k] = (ch[k] & LSB_CLEAR) | PIX_W'(len_bits[idx]);
			end
			hdr_seen = hdr_seen + 1'b1;
		end else if (res.ph == PH_PAYLOAD) begin
			for (k = 0; k < 3; k++) begin
				if (bits_done >= total_bits())
					break;
				// empty queue: leave the channel alone, retry the bit on the next one
				if (q_count == 0) begin
					res.st = ST_UNDERRUN;
					continue;
				end
				ch[k] = (ch[k] & LSB_CLEAR) | PIX_W'(q_bits[4'(q_count - 1'b1)]);
				q_count = q_count - 1'b1;
				bits_done = bits_done + 1'b1;
			end
		end
		res.red   = ch[0];
		res.green = ch[1];
		res.blue  = ch[2];
		return res;
	endfunction

	task automatic send_word(input cmd_t c, input logic [7:0] b,
			input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] bl);
		pixel_word_t due;
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		msg_byte <= b;
		red_in   <= r;
		green_in <= g;
		blue_in  <= bl;
		do @(posedge clk); while (!in_ready);
		due = embed_step(c, b, r, g, bl);
		embedded_due = {embedded_due, due};
	endtask

	task automatic push_byte(input logic [7:0] b);
		send_word(CMD_BYTE, b, PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
			PIX_W'($urandom_range(255)));
	endtask

	task automatic put_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] bl);
		send_word(CMD_PIXEL, 8'($urandom_range(255)), r, g, bl);
	endtask

	// Drop valid and hold until every expected word is back and the pipe is empty.
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (embedded_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_msg_bytes(input logic [MSG_BYTES_W-1:0] v);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		len_bytes = v;
	endtask

	function automatic logic [MSG_BYTES_W-1:0] bytes_done();
		return MSG_BYTES_W'(bits_done >> 3);
	endfunction

	task automatic run_mix(input int count, input int push_pct);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < push_pct)
				push_byte(8'($urandom_range(255)));
			else
				put_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
					PIX_W'($urandom_range(255)));
		end
	endtask

	task automatic test_header_length();
		int p;
		write_msg_bytes(20'hFFFFF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h5A);	// queue full: dropped
		for (p = 0; p < 8; p++) begin
			if (p[0])
				put_pixel(8'hFF, 8'h00, 8'hFF);
			else
				put_pixel(8'h00, 8'hFF, 8'h00);
		end
	endtask

	task automatic test_zero_length();
		int p;
		write_msg_bytes('0);
		for (p = 8; p < HEADER_PIXELS; p++)
			put_pixel(8'hFF, 8'hFF, 8'hFF);
		put_pixel(8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_payload_underrun();
		int p;
		write_msg_bytes(20'd3);
		// 16 queued bits run out on the red channel of the sixth pixel
		for (p = 0; p < 6; p++)
			put_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
				PIX_W'($urandom_range(255)));
		push_byte(8'hC3);
		for (p = 0; p < 3; p++)
			put_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
				PIX_W'($urandom_range(255)));
	endtask

	task automatic test_length_lowered();
		write_msg_bytes(20'd1);
		put_pixel(8'hA5, 8'h5A, 8'hFF);
	endtask

	task automatic test_free_flow();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		write_msg_bytes(bytes_done() + 20'd40);
		run_mix(200, 30);
	endtask

	task automatic test_sparse_source();
		src_idle_pct   = 64;
		sink_stall_pct = 0;
		write_msg_bytes(20'hFFFFF);
		run_mix(150, 28);
	endtask

	task automatic test_slow_sink();
		src_idle_pct   = 0;
		sink_stall_pct = 64;
		write_msg_bytes('0);
		run_mix(100, 30);
		write_msg_bytes(bytes_done() + 20'd25);
		run_mix(100, 30);
	endtask

	task automatic test_both_idle();
		src_idle_pct   = 9;
		sink_stall_pct = 9;
		write_msg_bytes(bytes_done() + 20'd30);
		run_mix(80, 22);
		settle_idle();
		run_mix(80, 35);
		write_msg_bytes(bytes_done() + 20'd5);
		run_mix(80, 30);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : check_words
		pixel_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (embedded_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected word: r=%h g=%h b=%h phase=%0d status=%0d",
						red_out, green_out, blue_out, phase, status);
			end else begin
				want = embedded_due.pop_front();
				if (red_out !== want.red || green_out !== want.green ||
						blue_out !== want.blue || phase !== want.ph || status !== want.st) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("mismatch: want r=%h g=%h b=%h phase=%0d status=%0d, got r=%h g=%h b=%h phase=%0d status=%0d",
							want.red, want.green, want.blue, want.ph, want.st,
							red_out, green_out, blue_out, phase, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		in_valid       = 1'b0;
		cmd            = CMD_BYTE;
		msg_byte       = '0;
		red_in         = '0;
		green_in       = '0;
		blue_in        = '0;
		out_ready      = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		arst_n         = 1'b0;
		len_bytes      = '0;
		hdr_seen       = '0;
		bits_done      = '0;
		q_bits         = '0;
		q_count        = '0;
		fail_count     = 0;
		cycle_count    = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_length();
		test_zero_length();
		test_payload_underrun();
		test_length_lowered();
		test_free_flow();
		test_sparse_source();
		test_slow_sink();
		test_both_idle();

		settle_idle();
		if (fail_count == 0 && embedded_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
